// ----- rtl/meinv_pkg.sv -----
// meinv_pkg: shared types and constants of the modular inverse unit.
// No dependencies; used by meinv_step_unit and modular_inverse_ext_euclid_unit.
package meinv_pkg;

	// operand width actually used (low bits of each input field)
	localparam int OPND_W = 63;
	localparam int COEF_W = 64;
	localparam int FIELD_W = 63;
	localparam int CNT_W = $clog2(OPND_W);

	typedef struct packed {
		logic [FIELD_W-1:0] number;
		logic [FIELD_W-1:0] modulus;
	} in_word_t;

	typedef struct packed {
		logic [FIELD_W-1:0] divisor;
		logic [COEF_W-1:0]  coef_number;
		logic [COEF_W-1:0]  coef_modulus;
		logic               coprime;
		logic [FIELD_W-1:0] inverse;
	} out_word_t;

	// step unit control and status
	typedef struct packed {
		logic go;
	} step_ctl_t;

	typedef struct packed {
		logic done;
		logic active;
	} step_stat_t;

endpackage

// ----- rtl/meinv_step_unit.sv -----
// meinv_step_unit: one Euclid step, restoring division one quotient bit per cycle,
// with the quotient times both coefficients formed MSB-first alongside. Uses meinv_pkg.
module meinv_step_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  meinv_pkg::step_ctl_t            ctl,
	input  logic [meinv_pkg::OPND_W-1:0]    divisor_in,
	input  logic [meinv_pkg::OPND_W-1:0]    dividend_in,
	input  logic [meinv_pkg::COEF_W-1:0]    coef_s_in,
	input  logic [meinv_pkg::COEF_W-1:0]    coef_t_in,
	output meinv_pkg::step_stat_t           stat,
	output logic [meinv_pkg::OPND_W-1:0]    rem,
	output logic [meinv_pkg::COEF_W-1:0]    prod_s,
	output logic [meinv_pkg::COEF_W-1:0]    prod_t
);

	logic                          active_q, done_q;
	logic [meinv_pkg::CNT_W-1:0]   cnt_q;
	logic [meinv_pkg::OPND_W-1:0]  rem_q, dvd_q, dsr_q;
	logic [meinv_pkg::COEF_W-1:0]  cs_q, ct_q, ps_q, pt_q;
	logic [meinv_pkg::OPND_W:0]    trial;
	logic [meinv_pkg::OPND_W:0]    diff;
	logic                          ge;
	logic                          last;

	// shared subtract and compare for one quotient bit
	always_comb begin
		trial = {rem_q, dvd_q[meinv_pkg::OPND_W-1]};
		diff  = trial - {1'b0, dsr_q};
		ge    = ~diff[meinv_pkg::OPND_W];
		last  = cnt_q == meinv_pkg::CNT_W'(meinv_pkg::OPND_W - 1);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.go) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctl.go) begin
			rem_q <= '0;
			dvd_q <= dividend_in;
			dsr_q <= divisor_in;
			cs_q  <= coef_s_in;
			ct_q  <= coef_t_in;
			ps_q  <= '0;
			pt_q  <= '0;
		end else if (active_q) begin
			rem_q <= ge ? diff[meinv_pkg::OPND_W-1:0] : trial[meinv_pkg::OPND_W-1:0];
			dvd_q <= {dvd_q[meinv_pkg::OPND_W-2:0], 1'b0};
			// Horner: p = 2p + qbit * coef
			ps_q  <= {ps_q[meinv_pkg::COEF_W-2:0], 1'b0} + (ge ? cs_q : '0);
			pt_q  <= {pt_q[meinv_pkg::COEF_W-2:0], 1'b0} + (ge ? ct_q : '0);
		end
	end

	assign stat.done   = done_q;
	assign stat.active = active_q;
	assign rem    = rem_q;
	assign prod_s = ps_q;
	assign prod_t = pt_q;

	// done only ends a run
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(active_q) && !active_q) else $error("step done without run");
	// a go is never issued mid run
	a_no_go_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.go |-> !active_q) else $error("step go while active");
	// remainder stays below divisor at the end
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> rem_q < dsr_q) else $error("remainder not reduced");

endmodule

// ----- rtl/modular_inverse_ext_euclid_unit.sv -----
// modular_inverse_ext_euclid_unit: extended Euclid gcd, Bezout coefficients, inverse.
// Depends on meinv_pkg and meinv_step_unit.
//
// channel   dir  handshake                       word
// operands  in   start & !busy                   meinv_pkg::in_word_t
// result    out  done (one cycle, no stall)      meinv_pkg::out_word_t
//
// Each Euclid step is one run of the bit-serial divider; up to ~92 steps for 63-bit
// operands. Number zero goes straight to normalization; modulus zero with a nonzero
// number takes one step.
// Reset clears the sequencer only; busy is low after reset.
// The result is shown for one cycle with done; the receiver cannot stall it.
module modular_inverse_ext_euclid_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  meinv_pkg::in_word_t   operands,
	output logic                  busy,
	output logic                  done,
	output meinv_pkg::out_word_t  result
);

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_CHECK = 4'b0010,
		ST_WAIT  = 4'b0100,
		ST_NORM  = 4'b1000
	} state_t;

	state_t                        state_q;
	logic                          done_q;
	meinv_pkg::out_word_t          result_q;
	logic [meinv_pkg::OPND_W-1:0]  a_q, b_q, m_q;
	logic [meinv_pkg::COEF_W-1:0]  sa_q, ta_q, sb_q, tb_q;
	meinv_pkg::step_ctl_t          step_ctl;
	meinv_pkg::step_stat_t         step_stat;
	logic [meinv_pkg::OPND_W-1:0]  step_rem;
	logic [meinv_pkg::COEF_W-1:0]  prod_s, prod_t;
	logic [meinv_pkg::COEF_W-1:0]  mag;
	logic [meinv_pkg::COEF_W-1:0]  m_ext;
	logic [meinv_pkg::OPND_W-1:0]  inv;

	meinv_step_unit u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (step_ctl),
		.divisor_in  (a_q),
		.dividend_in (b_q),
		.coef_s_in   (sa_q),
		.coef_t_in   (ta_q),
		.stat        (step_stat),
		.rem         (step_rem),
		.prod_s      (prod_s),
		.prod_t      (prod_t)
	);

	assign step_ctl.go = (state_q == ST_CHECK) && (a_q != '0);

	// normalize coef_number into 0..modulus-1; |coef| never exceeds modulus
	always_comb begin
		m_ext = meinv_pkg::COEF_W'(m_q);
		mag   = sb_q[meinv_pkg::COEF_W-1] ? (~sb_q + 1'b1) : sb_q;
		if (m_q == '0 || mag == '0 || mag == m_ext) begin
			inv = '0;
		end else if (sb_q[meinv_pkg::COEF_W-1]) begin
			inv = m_q - mag[meinv_pkg::OPND_W-1:0];
		end else begin
			inv = mag[meinv_pkg::OPND_W-1:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= (a_q != '0) ? ST_WAIT : ST_NORM;
				end
				ST_WAIT: begin
					if (step_stat.done) state_q <= ST_CHECK;
				end
				ST_NORM: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Euclid registers: b keeps the previous remainder, a the current one
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			a_q  <= operands.number[meinv_pkg::OPND_W-1:0];
			b_q  <= operands.modulus[meinv_pkg::OPND_W-1:0];
			m_q  <= operands.modulus[meinv_pkg::OPND_W-1:0];
			sa_q <= meinv_pkg::COEF_W'(1);
			ta_q <= '0;
			sb_q <= '0;
			tb_q <= meinv_pkg::COEF_W'(1);
		end else if (state_q == ST_WAIT && step_stat.done) begin
			a_q  <= step_rem;
			b_q  <= a_q;
			sa_q <= sb_q - prod_s;
			ta_q <= tb_q - prod_t;
			sb_q <= sa_q;
			tb_q <= ta_q;
		end
	end

	// result word
	always_ff @(posedge clk) begin
		if (state_q == ST_NORM) begin
			result_q.divisor      <= meinv_pkg::FIELD_W'(b_q);
			result_q.coef_number  <= sb_q;
			result_q.coef_modulus <= tb_q;
			result_q.coprime      <= b_q == meinv_pkg::OPND_W'(1);
			result_q.inverse      <= meinv_pkg::FIELD_W'(inv);
		end
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

	// a result only follows normalization
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(state_q == ST_NORM)) else $error("result without normalize");
	// coprime flag agrees with divisor
	a_coprime: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> result_q.coprime == (result_q.divisor == meinv_pkg::FIELD_W'(1)))
		else $error("coprime flag mismatch");
	// step unit finishes only while waited on
	a_step_wait: assert property (@(posedge clk) disable iff (!arst_n)
		step_stat.done |-> state_q == ST_WAIT) else $error("step done out of wait");

endmodule
